/* sv/srsd_pkg.sv */
// shared types, constants and the column map for the record sample deframer
// no dependencies
package srsd_pkg;

  // minimum tag length in bytes
  localparam int unsigned TAG_BYTES = 32;
  // minimum sample length in bytes
  localparam int unsigned MIN_SAMPLE_BYTES = 3;
  // tag byte offsets
  localparam logic [7:0] TAG_SCANS_LO  = 8'd10;
  localparam logic [7:0] TAG_SCANS_HI  = 8'd11;
  localparam logic [7:0] TAG_CHANNELS  = 8'd12;
  localparam logic [7:0] TAG_LENGTH    = 8'd13;
  localparam logic [7:0] TAG_SAMPLELEN = 8'd17;
  // most channel slots emitted per scan
  localparam int unsigned EMIT_SLOTS = 5;
  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // which byte of a sample a queued word carries
  typedef enum logic [1:0] {
    OP_LOW  = 2'd0,
    OP_MID  = 2'd1,
    OP_HIGH = 2'd2
  } srsd_op_kind_t;

  // one classified payload byte
  typedef struct packed {
    srsd_op_kind_t kind;
    logic [7:0]    data;
    logic [2:0]    column;
    logic [15:0]   scan;
    logic [15:0]   record;
    logic          last;
  } srsd_op_t;

  // queue occupancy and strobes
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } srsd_qstat_t;

  // slot to destination column
  function automatic logic [2:0] col_map(input logic [2:0] slot);
    logic [2:0] c;
    case (slot)
      3'd0:    c = 3'd3;
      3'd1:    c = 3'd4;
      3'd2:    c = 3'd0;
      3'd3:    c = 3'd1;
      3'd4:    c = 3'd2;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/srsd_ifs.sv */
// valid/ready channel interfaces for the byte input and the sample output
// depends on nothing
interface srsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface srsd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_value;
  logic        [2:0]  column;
  logic        [15:0] scan_index;
  logic        [15:0] record_index;
  logic               last_of_record;
  modport source (output valid, output sample_value, output column, output scan_index,
                  output record_index, output last_of_record, input ready);
  modport sink   (input valid, input sample_value, input column, input scan_index,
                  input record_index, input last_of_record, output ready);
endinterface

/* sv/srsd_front.sv */
// front part: takes bytes, parses tags, tracks scan/channel/sample counters
// depends on srsd_pkg and srsd_byte_if
module srsd_front
  import srsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  srsd_byte_if.sink        in_if,
  input  logic             q_full,
  output logic             push,
  output srsd_op_t         push_op
);

  logic        in_payload_r, in_payload_nxt;
  logic [7:0]  tag_cnt_r, tag_cnt_nxt;
  logic [15:0] spr_r, spr_nxt;
  logic [7:0]  chan_cnt_r, chan_cnt_nxt;
  logic [7:0]  tag_len_r, tag_len_nxt;
  logic [7:0]  samp_len_r, samp_len_nxt;
  logic [15:0] scan_r, scan_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [7:0]  sbc_r, sbc_nxt;
  logic [15:0] rec_r, rec_nxt;

  logic        acc;
  logic [7:0]  b;
  logic [2:0]  emitted;
  logic        last;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  // emitted slots per scan and the last-sample flag
  assign emitted = (chan_cnt_r < 8'(EMIT_SLOTS)) ? chan_cnt_r[2:0] : 3'(EMIT_SLOTS);
  assign last    = (({1'b0, scan_r} + 17'd1) == {1'b0, spr_r}) &&
                   (({1'b0, chan_r} + 9'd1) == {6'd0, emitted});

  // payload word for the queue
  always_comb begin
    push_op.data   = b;
    push_op.column = col_map(chan_r[2:0]);
    push_op.scan   = scan_r;
    push_op.record = rec_r;
    push_op.last   = last;
    case (sbc_r)
      8'd0:    push_op.kind = OP_LOW;
      8'd1:    push_op.kind = OP_MID;
      default: push_op.kind = OP_HIGH;
    endcase
  end

  assign push = acc && in_payload_r && (sbc_r < 8'(MIN_SAMPLE_BYTES)) &&
                (chan_r < 8'(EMIT_SLOTS));

  // tag parse and payload counters
  always_comb begin
    in_payload_nxt = in_payload_r;
    tag_cnt_nxt    = tag_cnt_r;
    spr_nxt        = spr_r;
    chan_cnt_nxt   = chan_cnt_r;
    tag_len_nxt    = tag_len_r;
    samp_len_nxt   = samp_len_r;
    scan_nxt       = scan_r;
    chan_nxt       = chan_r;
    sbc_nxt        = sbc_r;
    rec_nxt        = rec_r;
    if (acc) begin
      if (!in_payload_r) begin
        case (tag_cnt_r)
          TAG_SCANS_LO:  spr_nxt[7:0]  = b;
          TAG_SCANS_HI:  spr_nxt[15:8] = b;
          TAG_CHANNELS:  chan_cnt_nxt  = b;
          TAG_LENGTH:    tag_len_nxt   = (b < 8'(TAG_BYTES)) ? 8'(TAG_BYTES) : b;
          TAG_SAMPLELEN: samp_len_nxt  = (b < 8'(MIN_SAMPLE_BYTES)) ?
                                         8'(MIN_SAMPLE_BYTES) : b;
          default: ;
        endcase
        if ((tag_cnt_r >= TAG_LENGTH) &&
            (({1'b0, tag_cnt_r} + 9'd1) >= {1'b0, tag_len_nxt})) begin
          tag_cnt_nxt = 8'd0;
          if ((spr_nxt == 16'd0) || (chan_cnt_nxt == 8'd0)) begin
            // empty record ends with its tag
            rec_nxt = rec_r + 16'd1;
          end else begin
            in_payload_nxt = 1'b1;
            scan_nxt       = 16'd0;
            chan_nxt       = 8'd0;
            sbc_nxt        = 8'd0;
          end
        end else begin
          tag_cnt_nxt = tag_cnt_r + 8'd1;
        end
      end else begin
        if (({1'b0, sbc_r} + 9'd1) >= {1'b0, samp_len_r}) begin
          sbc_nxt = 8'd0;
          if (({1'b0, chan_r} + 9'd1) >= {1'b0, chan_cnt_r}) begin
            chan_nxt = 8'd0;
            if (({1'b0, scan_r} + 17'd1) >= {1'b0, spr_r}) begin
              scan_nxt       = 16'd0;
              rec_nxt        = rec_r + 16'd1;
              in_payload_nxt = 1'b0;
              tag_cnt_nxt    = 8'd0;
            end else begin
              scan_nxt = scan_r + 16'd1;
            end
          end else begin
            chan_nxt = chan_r + 8'd1;
          end
        end else begin
          sbc_nxt = sbc_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      tag_cnt_r    <= 8'd0;
      spr_r        <= 16'd0;
      chan_cnt_r   <= 8'd0;
      tag_len_r    <= 8'(TAG_BYTES);
      samp_len_r   <= 8'(MIN_SAMPLE_BYTES);
      scan_r       <= 16'd0;
      chan_r       <= 8'd0;
      sbc_r        <= 8'd0;
      rec_r        <= 16'd0;
    end else begin
      in_payload_r <= in_payload_nxt;
      tag_cnt_r    <= tag_cnt_nxt;
      spr_r        <= spr_nxt;
      chan_cnt_r   <= chan_cnt_nxt;
      tag_len_r    <= tag_len_nxt;
      samp_len_r   <= samp_len_nxt;
      scan_r       <= scan_nxt;
      chan_r       <= chan_nxt;
      sbc_r        <= sbc_nxt;
      rec_r        <= rec_nxt;
    end
  end

endmodule

/* sv/srsd_queue.sv */
// short queue of classified payload words between front and back
// depends on srsd_pkg
module srsd_queue
  import srsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  srsd_op_t    push_op,
  input  logic        pop,
  output logic        head_valid,
  output srsd_op_t    head_op,
  output srsd_qstat_t stat
);

  srsd_op_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (count_r != QCNT_W'(QDEPTH));
  assign do_pop  = pop && (count_r != '0);

  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rptr_r];

  assign stat.push  = push;
  assign stat.pop   = pop;
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  // pointer and count update
  always_comb begin
    wptr_nxt  = do_push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + QPTR_W'(1) : rptr_r;
    count_nxt = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

endmodule

/* sv/srsd_back.sv */
// back part: assembles 24-bit samples and holds the result word for output
// depends on srsd_pkg and srsd_sample_if
module srsd_back
  import srsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  srsd_op_t      head_op,
  output logic          pop,
  srsd_sample_if.source out_if
);

  logic [15:0]        acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [23:0] value_r;
  logic [2:0]         column_r;
  logic [15:0]        scan_r;
  logic [15:0]        rec_r;
  logic               last_r;
  logic               load;

  // a high byte waits only while the output register holds a result that is not being taken
  assign pop  = head_valid &&
                ((head_op.kind != OP_HIGH) || !out_valid_r || out_if.ready);
  assign load = pop && (head_op.kind == OP_HIGH);

  always_comb begin
    acc_nxt = acc_r;
    if (pop) begin
      case (head_op.kind)
        OP_LOW:  acc_nxt[7:0]  = head_op.data;
        OP_MID:  acc_nxt[15:8] = head_op.data;
        default: ;
      endcase
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= 16'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= {head_op.data, acc_r};
      column_r <= head_op.column;
      scan_r   <= head_op.scan;
      rec_r    <= head_op.record;
      last_r   <= head_op.last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.sample_value   = value_r;
  assign out_if.column         = column_r;
  assign out_if.scan_index     = scan_r;
  assign out_if.record_index   = rec_r;
  assign out_if.last_of_record = last_r;

endmodule

/* sv/sensor_record_sample_deframer_top.sv */
// top level of the record sample deframer: front, queue and back
// depends on srsd_pkg, srsd_ifs, srsd_front, srsd_queue, srsd_back
//
// channel  dir  signals                                                    word
// in_if    in   valid, ready, data_byte[7:0]                               one stream byte
// out_if   out  valid, ready, sample_value[23:0], column[2:0],             one sample
//               scan_index[15:0], record_index[15:0], last_of_record
//
// one byte is taken per cycle while the four-word queue has room
// a sample is loaded into the output register when its third byte leaves the queue, then
// sits in the output register until taken
// the output register alone limits the rate: a stalled output fills the queue
// and then holds in_if.ready low
// reset is synchronous and active low; no clearing pass
module sensor_record_sample_deframer_top
  import srsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  srsd_byte_if.sink     in_if,
  srsd_sample_if.source out_if
);

  logic        push;
  srsd_op_t    push_op;
  logic        pop;
  logic        head_valid;
  srsd_op_t    head_op;
  srsd_qstat_t qstat;

  srsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_full  (qstat.full),
    .push    (push),
    .push_op (push_op)
  );

  srsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .stat       (qstat)
  );

  srsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_if     (out_if)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !qstat.push)
    else $error("push into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !qstat.pop)
    else $error("pop from empty queue");

  // occupancy rises by one on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.push && !qstat.pop) |=> (qstat.count == $past(qstat.count) + QCNT_W'(1)))
    else $error("queue count did not advance on push");

  // a waiting result holds while the queue keeps the next high byte back
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.sample_value)))
    else $error("result lost while stalled");

endmodule
